// File: sv/ttdc_pkg.sv
// Shared types and constants for the touch tap/drag classifier.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ttdc_pkg;

    // Converter and field widths
    localparam int RAW_W      = 12;
    localparam int THRESH_W   = 13;
    localparam int LIMIT_W    = 16;
    localparam int TIME_W     = 32;
    localparam int POS_X_W    = 9;
    localparam int POS_Y_W    = 8;
    localparam int PATH_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Screen size defaults and the width that holds any supported size
    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;
    localparam int SIZE_W            = 13;

    // Depth of the queue between classifier and emitter
    localparam int CMDQ_DEPTH = 4;

    // Register reset values
    localparam logic [THRESH_W-1:0] RST_PRESSURE_THRESHOLD = 13'd300;
    localparam logic [LIMIT_W-1:0]  RST_TAP_DISTANCE_LIMIT = 16'd18;
    localparam logic [LIMIT_W-1:0]  RST_TAP_TIME_LIMIT_MS  = 16'd1500;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_DISTANCE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME_LIMIT_MS  = 2'd2;

    // Result event codes
    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_TAP     = 2'd1,
        EV_RELEASE = 2'd2
    } t_event_kind;

    // Command codes passed from classifier to emitter
    typedef enum logic [1:0] {
        CMD_MOVE        = 2'd0,
        CMD_RELEASE     = 2'd1,
        CMD_TAP_RELEASE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [RAW_W-1:0]  z1_reading;
        logic [RAW_W-1:0]  z2_reading;
        logic [RAW_W-1:0]  x_reading;
        logic [RAW_W-1:0]  y_reading;
        logic              display_on;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic               last_event;
    } t_out_item;

    typedef struct packed {
        logic [THRESH_W-1:0] pressure_threshold;
        logic [LIMIT_W-1:0]  tap_distance_limit;
        logic [LIMIT_W-1:0]  tap_time_limit_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/touch_tap_drag_classifier.sv
// Touch tap/drag classifier, top level: configuration registers and the
// classifier, command queue and emitter. Depends on ttdc_pkg and ttdc_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Takes one touch-converter poll sample per clock while full is low and turns
// it into move, tap and release events with screen coordinates. A sample is
// registered once, then updates the touch state and enters a four-entry command
// queue; the emitter drains the queue into the output register, so a move or a
// plain release passes the sample register and queue, and a release that counts
// as a tap yields two results (tap, then release). Samples flow at one per
// cycle while full is low; the emitter delivers one result per cycle unless the
// consumer stalls pop, so full rises only then or when taps outpace the output.
// Samples that cause no event (idle, or display off) take no output slot.
// Configuration is always ready and must be written while the block is idle.
module touch_tap_drag_classifier #(
    parameter int SCREEN_WIDTH  = ttdc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ttdc_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire ttdc_pkg::t_in_item                  i_in_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output ttdc_pkg::t_out_item                      o_out_item,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ttdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ttdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ttdc_pkg::*;

    t_cfg r_cfg;
    t_cmd fq_cmd;
    t_cmd qb_cmd;
    logic fq_push;
    logic q_full;
    logic q_empty;
    logic bq_pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressure_threshold <= RST_PRESSURE_THRESHOLD;
            r_cfg.tap_distance_limit <= RST_TAP_DISTANCE_LIMIT;
            r_cfg.tap_time_limit_ms  <= RST_TAP_TIME_LIMIT_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRESSURE_THRESHOLD: begin
                    r_cfg.pressure_threshold <= i_cfg_data[THRESH_W-1:0];
                end
                CFG_TAP_DISTANCE_LIMIT: begin
                    r_cfg.tap_distance_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                CFG_TAP_TIME_LIMIT_MS: begin
                    r_cfg.tap_time_limit_ms <= i_cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ttdc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_in_item),
        .o_cmd_push (fq_push),
        .o_cmd      (fq_cmd),
        .i_cmd_full (q_full)
    );

    ttdc_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_cmd   (fq_cmd),
        .o_full  (q_full),
        .i_pop   (bq_pop),
        .o_cmd   (qb_cmd),
        .o_empty (q_empty)
    );

    ttdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (qb_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (bq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

// File: sv/ttdc_front.sv
// Classifier front end: registers each sample, updates touch state, issues commands.
// Depends on ttdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttdc_front #(
    parameter int SCREEN_WIDTH  = ttdc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ttdc_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ttdc_pkg::t_cfg    i_cfg,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire ttdc_pkg::t_in_item i_item,
    output logic                   o_cmd_push,
    output ttdc_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_full
);
    import ttdc_pkg::*;

    localparam int PROD_W = RAW_W + SIZE_W;
    localparam int SUM_W  = PATH_W + 2;
    localparam logic [SIZE_W-1:0] X_SIZE = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0] Y_SIZE = SIZE_W'(SCREEN_HEIGHT);
    localparam logic [SIZE_W-1:0] X_MAX  = SIZE_W'(SCREEN_WIDTH - 1);
    localparam logic [SIZE_W-1:0] Y_MAX  = SIZE_W'(SCREEN_HEIGHT - 1);

    // raw * size / 4096, clamped to size - 1
    function automatic logic [SIZE_W-1:0] scale_coord(
        input logic [RAW_W-1:0]  raw,
        input logic [SIZE_W-1:0] size,
        input logic [SIZE_W-1:0] vmax
    );
        logic [PROD_W-1:0] prod;
        logic [SIZE_W-1:0] v;
        prod = PROD_W'(raw) * PROD_W'(size);
        v    = prod[PROD_W-1:RAW_W];
        return (v > vmax) ? vmax : v;
    endfunction

    // Sample stage
    logic                r_valid;
    logic                r_pressed;
    logic [POS_X_W-1:0]  r_x;
    logic [POS_Y_W-1:0]  r_y;
    logic                r_disp;
    logic [TIME_W-1:0]   r_now;

    // Touch state
    logic                r_is_pressed, n_is_pressed;
    logic [POS_X_W-1:0]  r_last_x, n_last_x;
    logic [POS_Y_W-1:0]  r_last_y, n_last_y;
    logic [PATH_W-1:0]   r_path, n_path;
    logic [TIME_W-1:0]   r_start, n_start;

    logic [THRESH_W-1:0] pressure;
    logic                pressed_now;
    logic [SIZE_W-1:0]   x_scaled;
    logic [SIZE_W-1:0]   y_scaled;
    logic                emit;
    logic                stall;
    logic                fire;
    logic                accept;
    logic [POS_X_W-1:0]  dx_abs;
    logic [POS_Y_W-1:0]  dy_abs;
    logic [SUM_W-1:0]    path_sum;
    logic [TIME_W-1:0]   duration;
    logic                tap_ok;

    // Pressure and screen coordinates of the incoming sample
    always_comb begin
        if (i_item.z1_reading != '0) begin
            pressure = THRESH_W'(i_item.z1_reading) + THRESH_W'(12'hFFF)
                     - THRESH_W'(i_item.z2_reading);
        end else begin
            pressure = '0;
        end
        pressed_now = (pressure >= i_cfg.pressure_threshold);
        x_scaled    = scale_coord(i_item.x_reading, X_SIZE, X_MAX);
        y_scaled    = scale_coord(i_item.y_reading, Y_SIZE, Y_MAX);
    end

    // Handshake: hold the sample stage while its command cannot enter the queue
    assign emit   = r_disp && (r_pressed || r_is_pressed);
    assign stall  = r_valid && emit && i_cmd_full;
    assign fire   = r_valid && !stall;
    assign accept = i_push && !stall;
    assign o_full = stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!stall) begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pressed <= pressed_now;
            r_x       <= x_scaled[POS_X_W-1:0];
            r_y       <= y_scaled[POS_Y_W-1:0];
            r_disp    <= i_item.display_on;
            r_now     <= i_item.now_ms;
        end
    end

    // Path increment, press duration and tap decision
    always_comb begin
        dx_abs   = (r_x > r_last_x) ? (r_x - r_last_x) : (r_last_x - r_x);
        dy_abs   = (r_y > r_last_y) ? (r_y - r_last_y) : (r_last_y - r_y);
        path_sum = SUM_W'(r_path) + SUM_W'(dx_abs) + SUM_W'(dy_abs);
        duration = r_now - r_start;
        tap_ok   = (r_path < i_cfg.tap_distance_limit)
                && (duration < TIME_W'(i_cfg.tap_time_limit_ms));
    end

    // Advance touch state
    always_comb begin
        n_is_pressed = r_is_pressed;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_path       = r_path;
        n_start      = r_start;
        if (fire) begin
            if (r_pressed) begin
                n_is_pressed = 1'b1;
                n_last_x     = r_x;
                n_last_y     = r_y;
                if (!r_is_pressed) begin
                    n_path  = '0;
                    n_start = r_now;
                end else if (path_sum > SUM_W'({PATH_W{1'b1}})) begin
                    n_path = {PATH_W{1'b1}};
                end else begin
                    n_path = path_sum[PATH_W-1:0];
                end
            end else if (r_is_pressed) begin
                n_is_pressed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pressed <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_path       <= '0;
            r_start      <= '0;
        end else begin
            r_is_pressed <= n_is_pressed;
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
            r_path       <= n_path;
            r_start      <= n_start;
        end
    end

    // Issue a command for every sample that produces events
    always_comb begin
        o_cmd_push = fire && emit;
        if (r_pressed) begin
            o_cmd.kind  = CMD_MOVE;
            o_cmd.pos_x = r_x;
            o_cmd.pos_y = r_y;
        end else begin
            o_cmd.kind  = tap_ok ? CMD_TAP_RELEASE : CMD_RELEASE;
            o_cmd.pos_x = r_last_x;
            o_cmd.pos_y = r_last_y;
        end
    end

endmodule

`default_nettype wire

// File: sv/ttdc_cmdq.sv
// Short command queue between the classifier and the event emitter.
// Depends on ttdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttdc_cmdq #(
    parameter int DEPTH = ttdc_pkg::CMDQ_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ttdc_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output ttdc_pkg::t_cmd      o_cmd,
    output logic                o_empty
);
    import ttdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/ttdc_back.sv
// Event emitter: expands queued commands into result events in an output register.
// Depends on ttdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttdc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ttdc_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ttdc_pkg::t_out_item o_item
);
    import ttdc_pkg::*;

    logic      r_out_valid;
    logic      r_tap_done;
    t_out_item r_item, n_item;
    logic      out_free;
    logic      load;
    logic      tap_first;

    // Load a waiting command whenever the output register is empty or being taken
    assign out_free  = !r_out_valid || i_pop;
    assign load      = out_free && !i_cmd_empty;
    assign tap_first = (i_cmd.kind == CMD_TAP_RELEASE) && !r_tap_done;
    assign o_cmd_pop = load && !tap_first;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_item;

    // Build the next event from the queue head
    always_comb begin
        n_item.pos_x      = i_cmd.pos_x;
        n_item.pos_y      = i_cmd.pos_y;
        n_item.last_event = !tap_first;
        case (i_cmd.kind)
            CMD_MOVE:        n_item.event_kind = EV_MOVE;
            CMD_TAP_RELEASE: n_item.event_kind = tap_first ? EV_TAP : EV_RELEASE;
            default:         n_item.event_kind = EV_RELEASE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tap_done  <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= !i_cmd_empty;
            end
            if (load) begin
                r_tap_done <= tap_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/ttdc_checker.sv
// Port-level checker for the touch tap/drag classifier and its bind.
// Depends on ttdc_pkg and touch_tap_drag_classifier.
`timescale 1ns / 1ps
`default_nettype none

module ttdc_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_full,
    input  wire logic                i_empty,
    input  wire logic                i_pop,
    input  wire ttdc_pkg::t_out_item i_out_item
);
    import ttdc_pkg::*;

    // Reset leaves no result and accepts samples
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("result or full flag after reset");

    // Hold a waiting result until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_out_item))
        else $error("waiting result changed before pop");

    // A tap is never the final event of its sample
    a_tap_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_out_item.event_kind == EV_TAP |-> !i_out_item.last_event)
        else $error("tap marked as last event");

    // Follow a taken tap at once with the final release
    a_tap_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_pop && i_out_item.event_kind == EV_TAP
        |=> !i_empty && i_out_item.event_kind == EV_RELEASE && i_out_item.last_event)
        else $error("tap not followed by release");

endmodule

bind touch_tap_drag_classifier ttdc_checker u_ttdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_full     (full),
    .i_empty    (empty),
    .i_pop      (pop),
    .i_out_item (o_out_item)
);

`default_nettype wire

// File: test/tb_touch_tap_drag_classifier.sv
// Self-checking testbench for the touch tap/drag classifier: drives poll samples
// and register writes, predicts move/tap/release events and checks each result.
// Depends on ttdc_pkg and the touch_tap_drag_classifier RTL.
`timescale 1ns / 1ps

module tb;
    import ttdc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 38;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // Expected-event ledger: mirrors the touch state and holds pending events
    class touch_event_ledger;
        logic [THRESH_W-1:0] thresh;
        logic [LIMIT_W-1:0]  dist_lim;
        logic [LIMIT_W-1:0]  time_lim;
        bit                  pressed;
        logic [POS_X_W-1:0]  last_x;
        logic [POS_Y_W-1:0]  last_y;
        logic [PATH_W-1:0]   path;
        logic [TIME_W-1:0]   start_ms;
        t_out_item           pending_events[$];
        int                  errors;
        int                  checked;
        int                  taps;

        function new();
            thresh   = RST_PRESSURE_THRESHOLD;
            dist_lim = RST_TAP_DISTANCE_LIMIT;
            time_lim = RST_TAP_TIME_LIMIT_MS;
            pressed  = 0;
            last_x   = '0;
            last_y   = '0;
            path     = '0;
            start_ms = '0;
            errors   = 0;
            checked  = 0;
            taps     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRESSURE_THRESHOLD: thresh = data[THRESH_W-1:0];
                CFG_TAP_DISTANCE_LIMIT: dist_lim = data;
                CFG_TAP_TIME_LIMIT_MS:  time_lim = data;
                default: ;
            endcase
        endfunction

        function int screen_coord(int raw, int size);
            int v;
            v = (raw * size) / 4096;
            if (v > size - 1) v = size - 1;
            return v;
        endfunction

        function void add_event(t_event_kind kind, logic [POS_X_W-1:0] x,
                                logic [POS_Y_W-1:0] y, logic last);
            t_out_item ev;
            ev.event_kind = kind;
            ev.pos_x      = x;
            ev.pos_y      = y;
            ev.last_event = last;
            pending_events.push_back(ev);
        endfunction

        // Advance the touch state by one accepted sample
        function void predict_sample(t_in_item s);
            int pressure;
            int dx;
            int dy;
            int sum;
            logic [TIME_W-1:0] dur;
            pressure = 0;
            if (s.z1_reading != 0)
                pressure = int'(s.z1_reading) + 4095 - int'(s.z2_reading);
            if (pressure >= int'(thresh)) begin
                dx = screen_coord(int'(s.x_reading), DEF_SCREEN_WIDTH) & 'h1FF;
                dy = screen_coord(int'(s.y_reading), DEF_SCREEN_HEIGHT) & 'hFF;
                if (!pressed) begin
                    pressed  = 1;
                    path     = '0;
                    start_ms = s.now_ms;
                end else begin
                    sum = int'(path);
                    sum += (dx > int'(last_x)) ? dx - int'(last_x) : int'(last_x) - dx;
                    sum += (dy > int'(last_y)) ? dy - int'(last_y) : int'(last_y) - dy;
                    path = (sum > 65535) ? 16'hFFFF : sum[PATH_W-1:0];
                end
                last_x = dx[POS_X_W-1:0];
                last_y = dy[POS_Y_W-1:0];
                if (s.display_on) add_event(EV_MOVE, last_x, last_y, 1'b1);
            end else if (pressed) begin
                dur     = s.now_ms - start_ms;
                pressed = 0;
                if (s.display_on) begin
                    if (path < dist_lim && dur < TIME_W'(time_lim))
                        add_event(EV_TAP, last_x, last_y, 1'b0);
                    add_event(EV_RELEASE, last_x, last_y, 1'b1);
                end
            end
        endfunction

        // Compare one popped event with the oldest pending one
        function void check_event(t_out_item got);
            t_out_item want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event kind=%0d x=%0d y=%0d last=%0d", $realtime,
                         got.event_kind, got.pos_x, got.pos_y, got.last_event);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            checked++;
            if (want.event_kind == EV_TAP) taps++;
            if (got.event_kind !== want.event_kind) begin
                $display("%0t: event_kind expected %0d got %0d", $realtime,
                         want.event_kind, got.event_kind);
                errors++;
            end
            if (got.pos_x !== want.pos_x) begin
                $display("%0t: pos_x expected %0d got %0d", $realtime, want.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== want.pos_y) begin
                $display("%0t: pos_y expected %0d got %0d", $realtime, want.pos_y, got.pos_y);
                errors++;
            end
            if (got.last_event !== want.last_event) begin
                $display("%0t: last_event expected %0d got %0d", $realtime,
                         want.last_event, got.last_event);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              in_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    touch_event_ledger ledger;
    bit                idle_on = 1;
    bit                hold_req = 0;
    int                stall_left = 0;
    int                cycle_count = 0;
    int                sent = 0;
    int                reg_writes = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    touch_tap_drag_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run length
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive pop: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            stall_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check each event taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) ledger.check_event(out_item);
    end

    // Offer one sample and hold the request until the block takes it
    task automatic send_sample(input t_in_item s);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        ledger.predict_sample(s);
        sent++;
    endtask

    task automatic send_fields(input logic [RAW_W-1:0] z1, input logic [RAW_W-1:0] z2,
                               input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                               input logic disp, input logic [TIME_W-1:0] now);
        t_in_item s;
        s.z1_reading = z1;
        s.z2_reading = z2;
        s.x_reading  = x;
        s.y_reading  = y;
        s.display_on = disp;
        s.now_ms     = now;
        send_sample(s);
    endtask

    // Drop the request and wait until every pending event has come out
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (ledger.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        ledger.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] path_lim,
                             input logic [CFG_DATA_W-1:0] dur);
        write_reg(CFG_PRESSURE_THRESHOLD, thr);
        write_reg(CFG_TAP_DISTANCE_LIMIT, path_lim);
        write_reg(CFG_TAP_TIME_LIMIT_MS, dur);
    endtask

    function automatic logic [RAW_W-1:0] nudge(input int v, input int span);
        int r;
        r = v + int'($urandom_range(0, 2 * span)) - span;
        if (r < 0) r = 0;
        if (r > 4095) r = 4095;
        return r[RAW_W-1:0];
    endfunction

    // Pressed sample: pressure of 4095 or more
    task automatic touch(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                         input logic disp);
        logic [RAW_W-1:0] z1;
        logic [RAW_W-1:0] z2;
        clock_ms += $urandom_range(1, 40);
        z1 = 12'($urandom_range(1, 4095));
        z2 = ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(0, z1));
        send_fields(z1, z2, x, y, disp, clock_ms);
    endtask

    // Lifted sample: no contact or a light one
    task automatic lift(input logic disp);
        logic [RAW_W-1:0] z1;
        logic [RAW_W-1:0] z2;
        clock_ms += $urandom_range(1, 40);
        if ($urandom_range(3) == 0) begin
            z1 = 12'($urandom_range(1, 400));
            z2 = 12'($urandom_range(3500, 4095));
        end else begin
            z1 = '0;
            z2 = 12'($urandom_range(0, 4095));
        end
        send_fields(z1, z2, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    disp, clock_ms);
    endtask

    task automatic noise_sample();
        clock_ms = $urandom;
        send_fields(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    1'($urandom_range(1)), clock_ms);
    endtask

    // One well-formed gesture with random content, or a stray sample
    task automatic gesture();
        int kind;
        int n;
        int x;
        int y;
        logic disp;
        kind = $urandom_range(0, 4);
        disp = ($urandom_range(99) < 85);
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        case (kind)
            0, 1: begin
                // quick tap with small jitter
                n = $urandom_range(1, 4);
                repeat (n) touch(nudge(x, 6), nudge(y, 6), disp ^ ($urandom_range(19) == 0));
                lift(disp);
            end
            2: begin
                // drag across the panel
                n = $urandom_range(3, 15);
                repeat (n) begin
                    x = nudge(x, 600);
                    y = nudge(y, 600);
                    touch(x, y, disp ^ ($urandom_range(19) == 0));
                end
                lift(disp);
            end
            3: begin
                // long press, duration may pass the tap limit
                touch(x, y, disp);
                clock_ms += $urandom_range(200, 3000);
                touch(nudge(x, 4), nudge(y, 4), disp);
                lift(disp);
            end
            default: noise_sample();
        endcase
    endtask

    task automatic run_gestures(input int count);
        int target;
        target = sent + count;
        while (sent < target) gesture();
    endtask

    task automatic run_noise(input int count);
        repeat (count) noise_sample();
    endtask

    initial begin
        ledger = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at reset configuration
        send_fields(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 32'd0);
        send_fields(12'd1, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 32'd5);
        send_fields(12'hFFF, 12'd0, 12'd0, 12'd0, 1'b1, 32'hFFFF_FFF0);
        send_fields(12'hFFF, 12'd0, 12'd0, 12'd0, 1'b1, 32'h0000_0010);
        send_fields(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 32'h0000_0020);
        send_fields(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 32'd100);
        send_fields(12'hFFF, 12'hFFF, 12'd0, 12'd0, 1'b1, 32'd110);
        send_fields(12'd0, 12'hFFF, 12'd0, 12'd0, 1'b1, 32'd120);
        send_fields(12'd2000, 12'd10, 12'd2048, 12'd2048, 1'b0, 32'd200);
        send_fields(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 32'd210);
        send_fields(12'd2000, 12'd10, 12'd2048, 12'd2048, 1'b0, 32'd300);
        send_fields(12'd2000, 12'd10, 12'd2048, 12'd1024, 1'b1, 32'd310);
        send_fields(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 32'd320);
        send_fields(12'd800, 12'd100, 12'd1000, 12'd1000, 1'b1, 32'd1000);
        send_fields(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 32'd2500);
        send_fields(12'd800, 12'd100, 12'd1000, 12'd1000, 1'b1, 32'd3000);
        send_fields(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 32'd4499);
        send_fields(12'd1, 12'd3796, 12'd3000, 12'd100, 1'b1, 32'd5000);
        send_fields(12'd1, 12'd3797, 12'd3000, 12'd100, 1'b1, 32'd5001);
        send_fields(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b1, 32'h5555_5555);
        send_fields(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b1, 32'h5555_5556);
        send_fields(12'd0, 12'h555, 12'hAAA, 12'h555, 1'b1, 32'hAAAA_AAAA);
        settle();

        // Random gestures at reset configuration
        run_gestures(100);
        settle();

        // Everything counts as pressed, taps impossible; no idling, then a hold-off
        write_all(16'd0, 16'd0, 16'd0);
        idle_on = 0;
        run_noise(20);
        hold_req = 1;
        run_noise(40);
        settle();
        idle_on = 1;

        // Nothing counts as pressed; the open press releases once
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_NO_REG, 16'h0001);
        run_noise(30);
        settle();

        // Pressure boundary at 4095; long corner-to-corner drag saturates the path
        write_all(16'd4095, 16'hFFFF, 16'hFFFF);
        clock_ms = 32'hFFFF_F000;
        for (int i = 0; i < 130; i++) begin
            touch((i % 2) ? 12'hFFF : 12'h000, (i % 2) ? 12'hFFF : 12'h000, 1'b1);
        end
        lift(1'b1);
        run_gestures(100);
        settle();

        // Tight limits and a threshold above the plain-contact level
        write_all(16'd5000, 16'd40, 16'd300);
        run_gestures(100);
        settle();

        // Back to reset values
        write_all(16'd300, 16'd18, 16'd1500);
        run_gestures(60);
        settle();

        $display("Run covered %0d samples and %0d register writes; %0d events checked, %0d taps.",
                 sent, reg_writes, ledger.checked, ledger.taps);
        $display("Thresholds 0 to 8191, time wrap, path saturation and display-off were exercised.");
        if (ledger.errors == 0 && ledger.pending_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
